/* rtl/bkvt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkvt_pkg
// Shared widths, codes and the result type of the key-value stream tokeniser.
// ----------------------------------------------------------------------------
package bkvt_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DEPTH_W  = 7;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned COUNT_W  = 18;
  localparam int unsigned EVENT_W  = 4;
  localparam int unsigned VTYPE_W  = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WCB_W    = 3;
  localparam int unsigned ITEM_W   = 4;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned LEN_W    = 16;

  // out_tdata: byte_out, depth_out, value_out, status, zero fill
  localparam int unsigned OUT_DATA_BITS = BYTE_W + DEPTH_W + VALUE_W + STATUS_W;
  localparam int unsigned OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;
  // out_tuser: event_kind, value_valid, value_type
  localparam int unsigned OUT_TUSER_W   = EVENT_W + 1 + VTYPE_W;

  // parser phases
  localparam logic [PHASE_W-1:0] PH_TYPE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NAME  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_STR   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_NUM   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_WLEN  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_WSKIP = 3'd5;

  // item types
  localparam logic [BYTE_W-1:0] T_NODE    = 8'd0;
  localparam logic [BYTE_W-1:0] T_STRING  = 8'd1;
  localparam logic [BYTE_W-1:0] T_INT32   = 8'd2;
  localparam logic [BYTE_W-1:0] T_FLOAT32 = 8'd3;
  localparam logic [BYTE_W-1:0] T_WIDE    = 8'd5;
  localparam logic [BYTE_W-1:0] T_UINT64  = 8'd7;
  localparam logic [BYTE_W-1:0] T_END     = 8'd8;

  // event kinds
  localparam logic [EVENT_W-1:0] EV_TYPE     = 4'd0;
  localparam logic [EVENT_W-1:0] EV_NAME     = 4'd1;
  localparam logic [EVENT_W-1:0] EV_NAME_END = 4'd2;
  localparam logic [EVENT_W-1:0] EV_STR      = 4'd3;
  localparam logic [EVENT_W-1:0] EV_STR_END  = 4'd4;
  localparam logic [EVENT_W-1:0] EV_NUM      = 4'd5;
  localparam logic [EVENT_W-1:0] EV_WLEN     = 4'd6;
  localparam logic [EVENT_W-1:0] EV_WSKIP    = 4'd7;
  localparam logic [EVENT_W-1:0] EV_OPEN     = 4'd8;
  localparam logic [EVENT_W-1:0] EV_NODE_END = 4'd9;
  localparam logic [EVENT_W-1:0] EV_IGNORED  = 4'd10;
  localparam logic [EVENT_W-1:0] EV_UNKNOWN  = 4'd11;

  // value types
  localparam logic [VTYPE_W-1:0] VT_INT32 = 2'd0;
  localparam logic [VTYPE_W-1:0] VT_U64   = 2'd1;
  localparam logic [VTYPE_W-1:0] VT_F32   = 2'd2;
  localparam logic [VTYPE_W-1:0] VT_U32   = 2'd3;

  // message status
  localparam logic [STATUS_W-1:0] ST_PARSING  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

  typedef struct packed {
    logic [EVENT_W-1:0]  event_kind;
    logic [BYTE_W-1:0]   byte_out;
    logic [DEPTH_W-1:0]  depth_out;
    logic [VALUE_W-1:0]  value_out;
    logic                value_valid;
    logic [VTYPE_W-1:0]  value_type;
    logic [STATUS_W-1:0] status;
  } bkvt_result_t;

endpackage

/* rtl/bkvt_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkvt_parser
// Parser state registers and the per-byte next-state and event logic.
// ----------------------------------------------------------------------------
module bkvt_parser #(
  parameter int MAX_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [bkvt_pkg::BYTE_W-1:0]    data_byte,
  input  logic                           first_byte,
  input  logic                           last_byte,
  input  logic [bkvt_pkg::WCB_W-1:0]     wide_char_bytes,
  output bkvt_pkg::bkvt_result_t         result
);
  import bkvt_pkg::*;

  localparam logic [DEPTH_W-1:0] MAX_DEPTH_V = DEPTH_W'(MAX_DEPTH);

  logic [PHASE_W-1:0]  phase_r,  phase_nxt;
  logic [DEPTH_W-1:0]  depth_r,  depth_nxt;
  logic [ITEM_W-1:0]   item_r,   item_nxt;
  logic [COUNT_W-1:0]  count_r,  count_nxt;
  logic [VALUE_W-1:0]  acc_r,    acc_nxt;
  logic [STATUS_W-1:0] fin_r,    fin_nxt;

  logic [PHASE_W-1:0]  cur_phase;
  logic [DEPTH_W-1:0]  cur_depth;
  logic [ITEM_W-1:0]   cur_item;
  logic [COUNT_W-1:0]  cur_count;
  logic [VALUE_W-1:0]  cur_acc;
  logic [STATUS_W-1:0] cur_fin;

  logic [COUNT_W-1:0]  count_inc;
  logic [COUNT_W-1:0]  need;
  logic [VALUE_W-1:0]  acc_num;
  logic [LEN_W-1:0]    wlen;
  logic [COUNT_W-1:0]  wlen_x;
  logic [COUNT_W-1:0]  skip_total;
  logic [COUNT_W-1:0]  count_dec;

  logic [EVENT_W-1:0]  ev;
  logic [VALUE_W-1:0]  val;
  logic                vvalid;
  logic [VTYPE_W-1:0]  vtype;

  // a first byte restarts the parser before the byte is taken
  always_comb begin
    if (first_byte) begin
      cur_phase = PH_TYPE;
      cur_depth = '0;
      cur_item  = '0;
      cur_count = '0;
      cur_acc   = '0;
      cur_fin   = ST_PARSING;
    end else begin
      cur_phase = phase_r;
      cur_depth = depth_r;
      cur_item  = item_r;
      cur_count = count_r;
      cur_acc   = acc_r;
      cur_fin   = fin_r;
    end
  end

  // number assembly, little-endian
  assign count_inc = cur_count + COUNT_W'(1);
  assign need      = ({4'd0, cur_item} == T_UINT64) ? COUNT_W'(8) : COUNT_W'(4);
  assign acc_num   = cur_acc | ({{(VALUE_W-BYTE_W){1'b0}}, data_byte}
                                << {cur_count[2:0], 3'b000});

  // wide string skip length, char width clamped to four
  assign wlen   = {data_byte, cur_acc[7:0]};
  assign wlen_x = {{(COUNT_W-LEN_W){1'b0}}, wlen};
  always_comb begin
    unique case (wide_char_bytes)
      3'd0:    skip_total = '0;
      3'd1:    skip_total = wlen_x;
      3'd2:    skip_total = wlen_x << 1;
      3'd3:    skip_total = wlen_x + (wlen_x << 1);
      default: skip_total = wlen_x << 2;
    endcase
  end

  assign count_dec = (cur_count != '0) ? cur_count - COUNT_W'(1) : cur_count;

  always_comb begin
    phase_nxt = cur_phase;
    depth_nxt = cur_depth;
    item_nxt  = cur_item;
    count_nxt = cur_count;
    acc_nxt   = cur_acc;
    fin_nxt   = cur_fin;
    ev        = EV_IGNORED;
    val       = '0;
    vvalid    = 1'b0;
    vtype     = VT_INT32;
    if (cur_fin == ST_PARSING) begin
      unique case (cur_phase)
        PH_TYPE: begin
          if (data_byte == T_END) begin
            ev = EV_NODE_END;
            if (cur_depth == '0) fin_nxt = ST_ACCEPTED;
            else                 depth_nxt = cur_depth - DEPTH_W'(1);
          end else if (data_byte > T_END) begin
            ev      = EV_UNKNOWN;
            fin_nxt = ST_REJECTED;
          end else begin
            ev        = EV_TYPE;
            item_nxt  = data_byte[ITEM_W-1:0];
            phase_nxt = PH_NAME;
          end
        end
        PH_NAME: begin
          if (data_byte != '0) begin
            ev = EV_NAME;
          end else begin
            ev        = EV_NAME_END;
            count_nxt = '0;
            acc_nxt   = '0;
            priority case ({4'd0, cur_item})
              T_NODE: begin
                ev = EV_OPEN;
                if (cur_depth >= MAX_DEPTH_V) fin_nxt = ST_REJECTED;
                else                          depth_nxt = cur_depth + DEPTH_W'(1);
                phase_nxt = PH_TYPE;
              end
              T_STRING: phase_nxt = PH_STR;
              T_WIDE:   phase_nxt = PH_WLEN;
              default:  phase_nxt = PH_NUM;
            endcase
          end
        end
        PH_STR: begin
          if (data_byte != '0) begin
            ev = EV_STR;
          end else begin
            ev        = EV_STR_END;
            phase_nxt = PH_TYPE;
          end
        end
        PH_NUM: begin
          ev        = EV_NUM;
          acc_nxt   = acc_num;
          count_nxt = count_inc;
          if (count_inc >= need) begin
            vvalid = 1'b1;
            priority case ({4'd0, cur_item})
              T_INT32: begin
                val   = {{32{acc_num[31]}}, acc_num[31:0]};
                vtype = VT_INT32;
              end
              T_UINT64: begin
                val   = acc_num;
                vtype = VT_U64;
              end
              T_FLOAT32: begin
                val   = {32'd0, acc_num[31:0]};
                vtype = VT_F32;
              end
              default: begin
                val   = {32'd0, acc_num[31:0]};
                vtype = VT_U32;
              end
            endcase
            acc_nxt   = '0;
            count_nxt = '0;
            phase_nxt = PH_TYPE;
          end
        end
        PH_WLEN: begin
          ev = EV_WLEN;
          if (cur_count == '0) begin
            acc_nxt   = {{(VALUE_W-BYTE_W){1'b0}}, data_byte};
            count_nxt = COUNT_W'(1);
          end else begin
            acc_nxt   = '0;
            count_nxt = skip_total;
            phase_nxt = (skip_total == '0) ? PH_TYPE : PH_WSKIP;
          end
        end
        default: begin
          ev        = EV_WSKIP;
          count_nxt = count_dec;
          if (count_dec == '0) phase_nxt = PH_TYPE;
        end
      endcase
      if (fin_nxt == ST_PARSING && last_byte) begin
        fin_nxt = (phase_nxt == PH_TYPE) ? ST_ACCEPTED : ST_REJECTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      depth_r <= '0;
      item_r  <= '0;
      count_r <= '0;
      acc_r   <= '0;
      fin_r   <= ST_PARSING;
    end else if (step) begin
      phase_r <= phase_nxt;
      depth_r <= depth_nxt;
      item_r  <= item_nxt;
      count_r <= count_nxt;
      acc_r   <= acc_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_comb begin
    result.event_kind  = ev;
    result.byte_out    = data_byte;
    result.depth_out   = depth_nxt;
    result.value_out   = val;
    result.value_valid = vvalid;
    result.value_type  = vtype;
    result.status      = fin_nxt;
  end

endmodule

/* rtl/bkvt_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkvt_out_reg
// Result register with valid flag; takes a new item whenever it is empty or
// being drained.
// ----------------------------------------------------------------------------
module bkvt_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  bkvt_pkg::bkvt_result_t res_in,
  output logic                   can_load,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bkvt_pkg::bkvt_result_t res_out
);
  import bkvt_pkg::*;

  logic         valid_r, valid_nxt;
  bkvt_result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

/* rtl/binary_keyvalue_stream_tokenizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_keyvalue_stream_tokenizer_core
// Result is registered: valid in the cycle after the input is accepted.
// Throughput: one item per cycle unless out_tready holds the result register.
// Result register frees as it is drained, so input stalls only on out_tready.
// Synchronous active-low reset: parser expects a type byte, depth zero,
// wide_char_bytes = 2, result register empty.
// ----------------------------------------------------------------------------
module binary_keyvalue_stream_tokenizer_core #(
  parameter int MAX_DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: data_byte[7:0]
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [bkvt_pkg::BYTE_W-1:0]           in_tdata,
  // in_tuser: first_byte
  input  logic                                  in_tuser,
  input  logic                                  in_tlast,
  // out_tdata: byte_out[7:0], depth_out[14:8], value_out[78:15],
  //            status[80:79], zero fill[87:81]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [bkvt_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: event_kind[3:0], value_valid[4], value_type[6:5]
  output logic [bkvt_pkg::OUT_TUSER_W-1:0]      out_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bkvt_pkg::WCB_W-1:0]            cfg_data
);
  import bkvt_pkg::*;

  logic [WCB_W-1:0] wcb_r;
  logic             in_fire;
  bkvt_result_t     res_d;
  bkvt_result_t     res_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcb_r <= WCB_W'(2);
    end else if (cfg_valid) begin
      wcb_r <= cfg_data;
    end
  end

  assign in_fire = in_tvalid && in_tready;

  bkvt_parser #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (in_fire),
    .data_byte       (in_tdata),
    .first_byte      (in_tuser),
    .last_byte       (in_tlast),
    .wide_char_bytes (wcb_r),
    .result          (res_d)
  );

  bkvt_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .res_in    (res_d),
    .can_load  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_q)
  );

  assign out_tdata = {{(OUT_TDATA_W-OUT_DATA_BITS){1'b0}},
                      res_q.status, res_q.value_out, res_q.depth_out, res_q.byte_out};
  assign out_tuser = {res_q.value_type, res_q.value_valid, res_q.event_kind};

endmodule

/* test/binary_keyvalue_stream_tokenizer_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_keyvalue_stream_tokenizer_core_test
// Feeds binary key-value messages into the tokeniser one byte per item and
// checks every event against a tokeniser kept in step inside the bench (or,
// for typed rows, the row's own event). A short table of hand-picked bytes
// comes first, then random messages under each char width setting: nested
// nodes, strings, numbers, wide strings, truncation, unknown types, depth
// overflow and noise. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module binary_keyvalue_stream_tokenizer_core_test;
  import bkvt_pkg::*;

  localparam int NEST_LIMIT  = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS = 30;
  localparam int FAULT_PRINT = 50;

  localparam int DEPTH_LSB  = BYTE_W;
  localparam int VALUE_LSB  = BYTE_W + DEPTH_W;
  localparam int STATUS_LSB = BYTE_W + DEPTH_W + VALUE_W;

  // numeric types with no name in the package
  localparam logic [BYTE_W-1:0] T_POINTER = 8'd4;
  localparam logic [BYTE_W-1:0] T_COLOUR  = 8'd6;

  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic                first;
    logic                last;
    logic                typed;
    logic [EVENT_W-1:0]  ev;
    logic [DEPTH_W-1:0]  depth;
    logic [VALUE_W-1:0]  value;
    logic                vvalid;
    logic [VTYPE_W-1:0]  vtype;
    logic [STATUS_W-1:0] st;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [WCB_W-1:0]       cfg_data   = '0;

  // tokeniser state kept by the bench
  logic [PHASE_W-1:0]  tk_phase  = PH_TYPE;
  logic [DEPTH_W-1:0]  tk_depth  = '0;
  logic [BYTE_W-1:0]   tk_type   = '0;
  logic [COUNT_W-1:0]  tk_count  = '0;
  logic [VALUE_W-1:0]  tk_acc    = '0;
  logic [STATUS_W-1:0] tk_status = ST_PARSING;
  logic [WCB_W-1:0]    char_width = 3'd2;

  bkvt_result_t  expected_events[$];
  logic [7:0]    msg_bytes[$];
  bit            msg_last;

  int  fault_count    = 0;
  int  results_seen   = 0;
  int  items_sent     = 0;
  int  phase_events   = 0;
  int  accepted_msgs  = 0;
  int  rejected_msgs  = 0;
  int  deepest        = 0;
  int  cycle_count    = 0;
  bit  tx_gaps        = 1'b1;
  bit  rx_gaps        = 1'b1;
  int  hold_requests  = 0;
  int  hold_seen      = 0;
  int  hold_left      = 0;
  int  rx_wait        = 0;
  bit  paused_once    = 1'b0;
  int  width_plan [7] = '{4, 0, 7, 3, 1, 5, 2};

  stim_row_t directed_rows [26] = '{
    '{8'h08, 1'b1, 1'b0, 1'b1, EV_NODE_END, 7'd0, 64'd0, 1'b0, VT_INT32, ST_ACCEPTED},
    '{8'h55, 1'b0, 1'b0, 1'b1, EV_IGNORED,  7'd0, 64'd0, 1'b0, VT_INT32, ST_ACCEPTED},
    '{8'h09, 1'b1, 1'b0, 1'b1, EV_UNKNOWN,  7'd0, 64'd0, 1'b0, VT_INT32, ST_REJECTED},
    '{8'hFF, 1'b1, 1'b0, 1'b1, EV_UNKNOWN,  7'd0, 64'd0, 1'b0, VT_INT32, ST_REJECTED},
    '{8'h02, 1'b1, 1'b0, 1'b1, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h00, 1'b0, 1'b0, 1'b1, EV_NAME_END, 7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h80, 1'b0, 1'b0, 1'b1, EV_NUM,      7'd0, 64'hFFFF_FFFF_8000_0000, 1'b1,
      VT_INT32, ST_PARSING},
    '{8'h01, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h61, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'hFF, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h05, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h01, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'hAB, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'hCD, 1'b0, 1'b1, 1'b1, EV_WSKIP,    7'd0, 64'd0, 1'b0, VT_INT32, ST_ACCEPTED},
    '{8'h03, 1'b1, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h00, 1'b0, 1'b0, 1'b0, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_PARSING},
    '{8'h11, 1'b0, 1'b1, 1'b1, EV_NUM,      7'd0, 64'd0, 1'b0, VT_INT32, ST_REJECTED},
    '{8'h00, 1'b1, 1'b1, 1'b1, EV_TYPE,     7'd0, 64'd0, 1'b0, VT_INT32, ST_REJECTED},
    '{8'h08, 1'b1, 1'b1, 1'b1, EV_NODE_END, 7'd0, 64'd0, 1'b0, VT_INT32, ST_ACCEPTED}
  };

  binary_keyvalue_stream_tokenizer_core #(
    .MAX_DEPTH(NEST_LIMIT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding", cycle_count,
               expected_events.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(12, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // next event of the tokeniser for one byte
  function automatic bkvt_result_t tokenize_byte(input logic [7:0] b, input logic first,
                                                 input logic last);
    bkvt_result_t        res;
    logic [15:0]         wlen;
    logic [COUNT_W-1:0]  wsize;
    logic [COUNT_W-1:0]  need;
    logic [STATUS_W-1:0] was;
    res = '0;
    res.event_kind = EV_IGNORED;
    res.byte_out = b;
    if (first) begin
      tk_phase  = PH_TYPE;
      tk_depth  = '0;
      tk_type   = '0;
      tk_count  = '0;
      tk_acc    = '0;
      tk_status = ST_PARSING;
    end
    was = tk_status;
    if (tk_status == ST_PARSING) begin
      case (tk_phase)
        PH_TYPE: begin
          if (b == T_END) begin
            res.event_kind = EV_NODE_END;
            if (tk_depth == '0) tk_status = ST_ACCEPTED;
            else tk_depth = tk_depth - 7'd1;
          end else if (b > T_END) begin
            res.event_kind = EV_UNKNOWN;
            tk_status = ST_REJECTED;
          end else begin
            res.event_kind = EV_TYPE;
            tk_type = b;
            tk_phase = PH_NAME;
          end
        end
        PH_NAME: begin
          if (b != 8'd0) begin
            res.event_kind = EV_NAME;
          end else begin
            tk_count = '0;
            tk_acc = '0;
            res.event_kind = EV_NAME_END;
            if (tk_type == T_NODE) begin
              res.event_kind = EV_OPEN;
              if (tk_depth >= DEPTH_W'(NEST_LIMIT)) tk_status = ST_REJECTED;
              else tk_depth = tk_depth + 7'd1;
              tk_phase = PH_TYPE;
            end else if (tk_type == T_STRING) begin
              tk_phase = PH_STR;
            end else if (tk_type == T_WIDE) begin
              tk_phase = PH_WLEN;
            end else begin
              tk_phase = PH_NUM;
            end
          end
        end
        PH_STR: begin
          if (b != 8'd0) begin
            res.event_kind = EV_STR;
          end else begin
            res.event_kind = EV_STR_END;
            tk_phase = PH_TYPE;
          end
        end
        PH_NUM: begin
          need = (tk_type == T_UINT64) ? 18'd8 : 18'd4;
          res.event_kind = EV_NUM;
          tk_acc = tk_acc | (64'(b) << (8 * tk_count[2:0]));
          tk_count = tk_count + 18'd1;
          if (tk_count >= need) begin
            res.value_valid = 1'b1;
            if (tk_type == T_INT32) begin
              res.value_out = {{32{tk_acc[31]}}, tk_acc[31:0]};
              res.value_type = VT_INT32;
            end else if (tk_type == T_UINT64) begin
              res.value_out = tk_acc;
              res.value_type = VT_U64;
            end else if (tk_type == T_FLOAT32) begin
              res.value_out = {32'd0, tk_acc[31:0]};
              res.value_type = VT_F32;
            end else begin
              res.value_out = {32'd0, tk_acc[31:0]};
              res.value_type = VT_U32;
            end
            tk_acc = '0;
            tk_count = '0;
            tk_phase = PH_TYPE;
          end
        end
        PH_WLEN: begin
          res.event_kind = EV_WLEN;
          if (tk_count == '0) begin
            tk_acc = 64'(b);
            tk_count = 18'd1;
          end else begin
            wlen = {b, tk_acc[7:0]};
            // widths above four are clamped
            wsize = (char_width > 3'd4) ? 18'd4 : 18'(char_width);
            tk_acc = '0;
            tk_count = 18'(wlen) * wsize;
            tk_phase = (tk_count == '0) ? PH_TYPE : PH_WSKIP;
          end
        end
        default: begin
          res.event_kind = EV_WSKIP;
          if (tk_count != '0) tk_count = tk_count - 18'd1;
          if (tk_count == '0) tk_phase = PH_TYPE;
        end
      endcase
      if (tk_status == ST_PARSING && last) begin
        tk_status = (tk_phase == PH_TYPE) ? ST_ACCEPTED : ST_REJECTED;
      end
    end
    if (was == ST_PARSING && tk_status == ST_ACCEPTED) accepted_msgs++;
    if (was == ST_PARSING && tk_status == ST_REJECTED) rejected_msgs++;
    if (int'(tk_depth) > deepest) deepest = tk_depth;
    res.depth_out = tk_depth;
    res.status = tk_status;
    return res;
  endfunction

  task automatic report_fault(input string what);
    fault_count++;
    if (fault_count <= FAULT_PRINT) $display("mismatch: %s", what);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_fault($sformatf("event %0d field %s got %0h want %0h", results_seen, name,
                             got, want));
    end
  endtask

  task automatic check_event();
    bkvt_result_t got;
    bkvt_result_t want;
    got.event_kind  = out_tuser[0 +: EVENT_W];
    got.value_valid = out_tuser[EVENT_W];
    got.value_type  = out_tuser[EVENT_W + 1 +: VTYPE_W];
    got.byte_out    = out_tdata[0 +: BYTE_W];
    got.depth_out   = out_tdata[DEPTH_LSB +: DEPTH_W];
    got.value_out   = out_tdata[VALUE_LSB +: VALUE_W];
    got.status      = out_tdata[STATUS_LSB +: STATUS_W];
    results_seen++;
    if (expected_events.size() == 0) begin
      report_fault($sformatf("event %0d arrived with none pending, kind %0d byte %02h",
                             results_seen, got.event_kind, got.byte_out));
      return;
    end
    want = expected_events.pop_front();
    compare_field("event_kind", 64'(got.event_kind), 64'(want.event_kind));
    compare_field("byte_out", 64'(got.byte_out), 64'(want.byte_out));
    compare_field("depth_out", 64'(got.depth_out), 64'(want.depth_out));
    compare_field("value_out", got.value_out, want.value_out);
    compare_field("value_valid", 64'(got.value_valid), 64'(want.value_valid));
    compare_field("value_type", 64'(got.value_type), 64'(want.value_type));
    compare_field("status", 64'(got.status), 64'(want.status));
  endtask

  // result side: check, then pick the ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_event();
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait--;
    end else begin
      out_tready <= 1'b1;
      if (rx_gaps && $urandom_range(0, 4) == 0) rx_wait = pick_gap();
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic typed, input bkvt_result_t typed_event);
    bkvt_result_t ev;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    ev = tokenize_byte(b, first, last);
    if (typed) ev = typed_event;
    expected_events.push_back(ev);
    items_sent++;
    if (ev.event_kind != EV_IGNORED) phase_events++;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_char_width(input logic [WCB_W-1:0] w);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    char_width = w;
  endtask

  task automatic add_header(input logic [7:0] kind);
    int n;
    msg_bytes.push_back(kind);
    n = $urandom_range(0, 4);
    repeat (n) msg_bytes.push_back(8'($urandom_range(1, 255)));
    msg_bytes.push_back(8'h00);
  endtask

  function automatic logic [7:0] number_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed messages, some cut short, broken or pure noise
  task automatic build_message();
    int          mode;
    int          n_items;
    int          depth;
    int          pick;
    int          eff_w;
    int          n;
    logic [7:0]  kind;
    logic [15:0] wlen;
    bit          cut;
    logic [7:0]  number_kinds [5];
    number_kinds = '{T_INT32, T_FLOAT32, T_POINTER, T_COLOUR, T_UINT64};
    msg_bytes.delete();
    cut = 1'b0;
    depth = 0;
    msg_last = 1'b1;
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) msg_bytes.push_back(8'($urandom));
      msg_last = 1'($urandom_range(0, 1));
      return;
    end
    n_items = $urandom_range(1, 8);
    for (int i = 0; i < n_items && !cut; i++) begin
      pick = $urandom_range(0, 9);
      if (pick <= 1 && depth < 6) begin
        add_header(T_NODE);
        depth++;
      end else if (pick == 2 && depth > 0) begin
        msg_bytes.push_back(T_END);
        depth--;
      end else if (pick == 3) begin
        add_header(T_STRING);
        n = $urandom_range(0, 5);
        repeat (n) msg_bytes.push_back(8'($urandom_range(1, 255)));
        msg_bytes.push_back(8'h00);
      end else if (pick == 4) begin
        add_header(T_WIDE);
        eff_w = (char_width > 3'd4) ? 4 : int'(char_width);
        if (eff_w == 0) begin
          wlen = 16'($urandom);
        end else if ($urandom_range(0, 9) == 0) begin
          // huge length, cut off after a few skipped bytes
          wlen = 16'hFFFF;
          cut = 1'b1;
        end else begin
          wlen = 16'($urandom_range(0, 3));
        end
        msg_bytes.push_back(wlen[7:0]);
        msg_bytes.push_back(wlen[15:8]);
        n = cut ? 3 : int'(wlen) * eff_w;
        repeat (n) msg_bytes.push_back(8'($urandom));
      end else begin
        kind = number_kinds[$urandom_range(0, 4)];
        add_header(kind);
        n = (kind == T_UINT64) ? 8 : 4;
        repeat (n) msg_bytes.push_back(number_byte());
      end
    end
    if (cut) return;
    if (mode <= 10) begin
      repeat (depth + 1) msg_bytes.push_back(T_END);
      n = $urandom_range(0, 3);
      repeat (n) msg_bytes.push_back(8'($urandom));
      msg_last = 1'($urandom_range(0, 1));
    end else if (mode <= 15 && mode > 13) begin
      n = $urandom_range(1, 3);
      repeat (n) if (msg_bytes.size() > 1) void'(msg_bytes.pop_back());
    end else if (mode <= 17 && mode > 13) begin
      msg_bytes.push_back(8'($urandom_range(9, 255)));
      n = $urandom_range(0, 3);
      repeat (n) msg_bytes.push_back(8'($urandom));
    end else if (mode > 17) begin
      // left unfinished, the next first byte restarts the parser
      msg_last = 1'b0;
    end
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_byte(msg_bytes[i], i == 0, msg_last && (i == msg_bytes.size() - 1), 1'b0, '0);
    end
  endtask

  initial begin
    stim_row_t    row;
    bkvt_result_t typed_event;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      typed_event = '0;
      typed_event.event_kind  = row.ev;
      typed_event.byte_out    = row.data;
      typed_event.depth_out   = row.depth;
      typed_event.value_out   = row.value;
      typed_event.value_valid = row.vvalid;
      typed_event.value_type  = row.vtype;
      typed_event.status      = row.st;
      send_byte(row.data, row.first, row.last, row.typed, typed_event);
    end

    foreach (width_plan[p]) begin
      settle();
      write_char_width(WCB_W'(width_plan[p]));
      tx_gaps = (p != 1);
      rx_gaps = (p != 1);
      phase_events = 0;
      if (p == 0) begin
        // nest one level past the limit
        msg_bytes.delete();
        repeat (NEST_LIMIT + 1) begin
          msg_bytes.push_back(T_NODE);
          msg_bytes.push_back(8'h00);
        end
        msg_bytes.push_back(T_STRING);
        msg_bytes.push_back(8'h41);
        msg_last = 1'b0;
        send_message();
      end
      if (p == 2) begin
        tx_gaps = 1'b0;
        hold_requests++;
      end
      while (phase_events < PHASE_ITEMS) begin
        build_message();
        send_message();
        if (p == 3 && !paused_once) begin
          settle();
          paused_once = 1'b1;
        end
      end
    end

    settle();
    if (expected_events.size() != 0) report_fault("events still pending at the end");
    $display("sent %0d items, checked %0d events, %0d messages accepted, %0d rejected",
             items_sent, results_seen, accepted_msgs, rejected_msgs);
    $display("char widths 2 4 0 7 3 1 5 2, deepest nesting %0d, %0d faults",
             deepest, fault_count);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
